### hdl/color_blend_unit_core_defines.svh
// assertion macros used by the port-level checker file
// no dependencies
`ifndef COLOR_BLEND_UNIT_CORE_DEFINES_SVH
`define COLOR_BLEND_UNIT_CORE_DEFINES_SVH
`define CBU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbu check failed");
`define CBU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbu check failed");
`endif

### hdl/cbu_pkg.sv
// types, mode codes and helpers for the colour blend unit
// no dependencies
`default_nettype none
package cbu_pkg;
    typedef enum logic [3:0] {
        OP_KEEP = 4'd0, OP_SET = 4'd1, OP_MUL = 4'd2, OP_LIGHTEN = 4'd3,
        OP_DARKEN = 4'd4, OP_SCREEN = 4'd5, OP_DODGE = 4'd6, OP_CBURN = 4'd7,
        OP_ADD = 4'd8, OP_ADDALPHA = 4'd9, OP_BURN = 4'd10, OP_OVERLAY = 4'd11,
        OP_LERP = 4'd12, OP_BAD0 = 4'd13, OP_BAD1 = 4'd14, OP_BAD2 = 4'd15
    } t_op;

    localparam int unsigned CH_MAX = 255;
    localparam int unsigned DIV_STEPS = 16;

    // stage 1 output of one channel: numerator and divisor set up, divide flag and direct result
    typedef struct packed {
        logic [15:0] num;
        logic [7:0]  den;
        logic        div;
        logic [7:0]  dir;
    } t_ch_s1;

    // floor(x/255), exact for x up to 255*255 + 254
    function automatic logic [8:0] div255(input logic [16:0] x);
        logic [17:0] q;
        q = ({1'b0, x} + {9'd0, x[16:8]} + 18'd1) >> 8;
        return q[8:0];
    endfunction
endpackage
`default_nettype wire

### hdl/color_blend_unit_core.sv
// colour blend unit top level: four channel lanes and the valid pipeline
// depends on cbu_pkg and cbu_chan
//
// usage
//   input channel: i_valid with op, amount and two rgba colours; a request
//   is taken when i_valid is high and o_stall is low
//   output channel: o_valid with the blended rgba colour; taken when
//   o_valid is high and i_stall is low
//   throughput: one request per cycle when not stalled, set by the
//   five-stage pipeline of set-up and four divider stages of four
//   quotient bits each
//   reset clears every valid bit; payload registers are not reset
//   a stall from the receiver freezes the whole pipeline, so o_stall
//   follows i_stall only while the pipeline holds a result at its end;
//   bubbles inside the pipeline stay in place while it is frozen
//   alpha passes the existing alpha for dodge, colour burn and overlay,
//   and undefined modes give opaque black
`default_nettype none
module color_blend_unit_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [3:0] i_op,
    input  wire logic [7:0] i_amount,
    input  wire logic [7:0] i_existing_red,
    input  wire logic [7:0] i_existing_green,
    input  wire logic [7:0] i_existing_blue,
    input  wire logic [7:0] i_existing_alpha,
    input  wire logic [7:0] i_current_red,
    input  wire logic [7:0] i_current_green,
    input  wire logic [7:0] i_current_blue,
    input  wire logic [7:0] i_current_alpha,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic [7:0]      o_out_alpha
);
    localparam int unsigned LAT = 5;
    logic [LAT-1:0] r_vld;
    logic w_en;
    logic [3:0] w_aop;
    logic [7:0] w_r, w_g, w_b, w_a;
    logic [LAT-1:0] r_black;

    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // rgb-only modes keep alpha, undefined modes force opaque black
    always_comb begin
        case (i_op) inside
            cbu_pkg::OP_DODGE, cbu_pkg::OP_CBURN,
            cbu_pkg::OP_OVERLAY: w_aop = cbu_pkg::OP_KEEP;
            cbu_pkg::OP_BAD0, cbu_pkg::OP_BAD1,
            cbu_pkg::OP_BAD2: w_aop = cbu_pkg::OP_BAD0;
            default: w_aop = i_op;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_black <= {r_black[LAT-2:0], (i_op > cbu_pkg::OP_LERP)};
    end

    cbu_chan u_r (.i_clk(i_clk), .i_en(w_en), .i_op(i_op), .i_amount(i_amount),
        .i_e(i_existing_red), .i_c(i_current_red), .o_v(w_r));
    cbu_chan u_g (.i_clk(i_clk), .i_en(w_en), .i_op(i_op), .i_amount(i_amount),
        .i_e(i_existing_green), .i_c(i_current_green), .o_v(w_g));
    cbu_chan u_b (.i_clk(i_clk), .i_en(w_en), .i_op(i_op), .i_amount(i_amount),
        .i_e(i_existing_blue), .i_c(i_current_blue), .o_v(w_b));
    cbu_chan u_a (.i_clk(i_clk), .i_en(w_en), .i_op(w_aop), .i_amount(i_amount),
        .i_e(i_existing_alpha), .i_c(i_current_alpha), .o_v(w_a));

    assign o_out_red   = w_r;
    assign o_out_green = w_g;
    assign o_out_blue  = w_b;
    assign o_out_alpha = r_black[LAT-1] ? 8'hff : w_a;
endmodule
`default_nettype wire

### hdl/cbu_div.sv
// pipelined restoring divider, one quotient bit a step, saturating at 255
// depends on cbu_pkg
`default_nettype none
module cbu_div (
    input  wire logic        i_clk,
    input  wire logic        i_en,
    input  wire logic [15:0] i_num,
    input  wire logic [7:0]  i_den,
    output logic      [7:0]  o_q
);
    localparam int unsigned N = cbu_pkg::DIV_STEPS;
    localparam int unsigned STAGES = 4;
    localparam int unsigned BITS = N / STAGES;
    logic [15:0] r_num [1:STAGES-1];
    logic [8:0]  r_rem [1:STAGES-1];
    logic [7:0]  r_den [1:STAGES-1];
    logic [15:0] r_q   [1:STAGES];

    // four quotient bits a pipeline register
    for (genvar s = 0; s < STAGES; s++) begin : g_st
        logic [15:0] w_num, w_q, n_num, n_q;
        logic [8:0]  w_rem, n_rem;
        logic [7:0]  w_den;
        if (s == 0) begin : g_first
            assign w_num = i_num;
            assign w_q   = '0;
            assign w_rem = '0;
            assign w_den = i_den;
        end else begin : g_next
            assign w_num = r_num[s];
            assign w_q   = r_q[s];
            assign w_rem = r_rem[s];
            assign w_den = r_den[s];
        end
        always_comb begin
            logic [9:0] t;
            n_num = w_num;
            n_q   = w_q;
            n_rem = w_rem;
            t     = '0;
            for (int k = 0; k < BITS; k++) begin
                t = {n_rem, n_num[15]};
                n_num = {n_num[14:0], 1'b0};
                if (t >= {2'b0, w_den}) begin
                    t = t - {2'b0, w_den};
                    n_q = {n_q[14:0], 1'b1};
                end else begin
                    n_q = {n_q[14:0], 1'b0};
                end
                n_rem = t[8:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) r_q[s+1] <= n_q;
        end
        if (s < STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_num[s+1] <= n_num;
                    r_rem[s+1] <= n_rem;
                    r_den[s+1] <= w_den;
                end
            end
        end
    end

    assign o_q = (r_q[STAGES][15:8] != '0) ? 8'hff : r_q[STAGES][7:0];
endmodule
`default_nettype wire

### hdl/cbu_chan.sv
// one colour channel: front end, divider and final select
// depends on cbu_pkg and cbu_div
`default_nettype none
module cbu_chan (
    input  wire logic       i_clk,
    input  wire logic       i_en,
    input  wire logic [3:0] i_op,
    input  wire logic [7:0] i_amount,
    input  wire logic [7:0] i_e,
    input  wire logic [7:0] i_c,
    output logic      [7:0] o_v
);
    localparam int unsigned LAT = 4;
    cbu_pkg::t_ch_s1 n_s1, r_s1;
    logic [LAT-1:0][7:0] r_dir;
    logic [LAT-1:0]      r_div;
    logic [7:0] w_q;

    always_comb begin
        logic [7:0]  ie, ic;
        logic [16:0] p;
        logic [8:0]  d, s9;
        ie = 8'hff - i_e;
        ic = 8'hff - i_c;
        n_s1 = '0;
        p = '0; d = '0; s9 = '0;
        case (i_op)
            cbu_pkg::OP_KEEP:    n_s1.dir = i_e;
            cbu_pkg::OP_SET:     n_s1.dir = i_c;
            cbu_pkg::OP_MUL: begin
                p = 17'(i_e) * 17'(i_c) + 17'd127;
                d = cbu_pkg::div255(p);
                n_s1.dir = d[7:0];
            end
            cbu_pkg::OP_LIGHTEN: n_s1.dir = (i_e > i_c) ? i_e : i_c;
            cbu_pkg::OP_DARKEN:  n_s1.dir = (i_e < i_c) ? i_e : i_c;
            cbu_pkg::OP_SCREEN: begin
                p = 17'(ie) * 17'(ic) + 17'd127;
                d = cbu_pkg::div255(p);
                n_s1.dir = 8'hff - d[7:0];
            end
            cbu_pkg::OP_DODGE: begin
                if (i_e == 8'hff) n_s1.dir = 8'hff;
                else begin
                    n_s1.div = 1'b1;
                    n_s1.num = {i_c, 8'h00} - {8'h00, i_c};
                    n_s1.den = ie;
                end
            end
            cbu_pkg::OP_CBURN: begin
                if (i_e != 8'h00) begin
                    n_s1.div = 1'b1;
                    n_s1.num = {ic, 8'h00} - {8'h00, ic};
                    n_s1.den = i_e;
                end
            end
            cbu_pkg::OP_ADD: begin
                s9 = {1'b0, i_e} + {1'b0, i_c};
                n_s1.dir = s9[8] ? 8'hff : s9[7:0];
            end
            cbu_pkg::OP_ADDALPHA: begin
                p = 17'(i_amount) * 17'(i_c) + 17'd127;
                d = cbu_pkg::div255(p);
                s9 = {1'b0, i_e} + d;
                n_s1.dir = s9[8] ? 8'hff : s9[7:0];
            end
            cbu_pkg::OP_BURN: begin
                s9 = {1'b0, i_e} + {1'b0, i_c};
                n_s1.dir = (s9 > 9'd255) ? 8'(s9 - 9'd255) : 8'h00;
            end
            cbu_pkg::OP_OVERLAY: begin
                if (i_c <= 8'd127) begin
                    p = {16'(i_c) * 16'(i_e), 1'b0} + 17'd127;
                    d = cbu_pkg::div255(p);
                    n_s1.dir = (d > 9'd255) ? 8'hff : d[7:0];
                end else begin
                    p = {16'(ic) * 16'(ie), 1'b0} + 17'd127;
                    d = cbu_pkg::div255(p);
                    n_s1.dir = (d > 9'd255) ? 8'h00 : 8'hff - d[7:0];
                end
            end
            cbu_pkg::OP_LERP: begin
                p = 17'(i_e) * 17'(8'hff - i_amount) + 17'(i_c) * 17'(i_amount)
                    + 17'd127;
                d = cbu_pkg::div255(p);
                n_s1.dir = (d > 9'd255) ? 8'hff : d[7:0];
            end
            default: n_s1.dir = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_s1 <= n_s1;
    end

    cbu_div u_div (
        .i_clk(i_clk), .i_en(i_en), .i_num(r_s1.num), .i_den(r_s1.den), .o_q(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dir[0] <= r_s1.dir;
            r_div[0] <= r_s1.div;
            for (int k = 1; k < LAT; k++) begin
                r_dir[k] <= r_dir[k-1];
                r_div[k] <= r_div[k-1];
            end
        end
    end

    assign o_v = r_div[LAT-1] ? w_q : r_dir[LAT-1];
endmodule
`default_nettype wire

### hdl/cbu_checker.sv
// port-level checks for the colour blend unit, bound to the top level
// depends on color_blend_unit_core_defines.svh
`include "color_blend_unit_core_defines.svh"
`default_nettype none
module cbu_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic o_stall,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire logic [7:0] o_out_red,
    input wire logic [7:0] o_out_alpha
);
    `CBU_ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `CBU_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)
    `CBU_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall,
        $stable(o_out_red) && $stable(o_out_alpha))
    `CBU_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid)
endmodule
bind color_blend_unit_core cbu_checker u_cbu_checker (.*);
`default_nettype wire

### test/tb_color_blend_unit_core.sv
// testbench for the colour blend unit: directed and random requests with a blend predictor
// depends on cbu_pkg and color_blend_unit_core
`timescale 1ns / 100ps
`default_nettype none
module tb_color_blend_unit_core;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    logic         clk;
    logic         rst_n;
    logic         in_valid;
    logic         in_stall;
    logic         out_valid;
    logic         out_stall;
    cbu_pkg::t_op op;
    logic [7:0]   amount;
    t_rgba        ex_col;
    t_rgba        cur_col;
    t_rgba        res_col;

    t_rgba blend_q[$];
    int    errors;
    int    n_sent;
    int    n_recv;
    int    idle_cycles;
    bit    no_idle;

    color_blend_unit_core dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(out_stall),
        .i_op(op), .i_amount(amount),
        .i_existing_red(ex_col.r), .i_existing_green(ex_col.g),
        .i_existing_blue(ex_col.b), .i_existing_alpha(ex_col.a),
        .i_current_red(cur_col.r), .i_current_green(cur_col.g),
        .i_current_blue(cur_col.b), .i_current_alpha(cur_col.a),
        .o_valid(out_valid), .i_stall(in_stall),
        .o_out_red(res_col.r), .o_out_green(res_col.g),
        .o_out_blue(res_col.b), .o_out_alpha(res_col.a)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned mul_rnd(int unsigned x, int unsigned y);
        return (x * y + 127) / 255;
    endfunction

    function automatic int unsigned clip(int unsigned v);
        return v > 255 ? 255 : v;
    endfunction

    function automatic logic [7:0] blend_lane(cbu_pkg::t_op m, int unsigned amt,
                                              int unsigned e, int unsigned c);
        int unsigned p;
        case (m)
            cbu_pkg::OP_KEEP:     return 8'(e);
            cbu_pkg::OP_SET:      return 8'(c);
            cbu_pkg::OP_MUL:      return 8'(mul_rnd(e, c));
            cbu_pkg::OP_LIGHTEN:  return 8'(e > c ? e : c);
            cbu_pkg::OP_DARKEN:   return 8'(e < c ? e : c);
            cbu_pkg::OP_SCREEN:   return 8'(255 - mul_rnd(255 - e, 255 - c));
            cbu_pkg::OP_DODGE:    return 8'(e == 255 ? 255 : clip((c * 255) / (255 - e)));
            cbu_pkg::OP_CBURN:    return 8'(e == 0 ? 0 : clip(((255 - c) * 255) / e));
            cbu_pkg::OP_ADD:      return 8'(clip(e + c));
            cbu_pkg::OP_ADDALPHA: return 8'(clip(e + mul_rnd(amt, c)));
            cbu_pkg::OP_BURN:     return 8'(e + c > 255 ? e + c - 255 : 0);
            cbu_pkg::OP_OVERLAY: begin
                if (c <= 127) return 8'(clip((2 * c * e + 127) / 255));
                p = (2 * (255 - c) * (255 - e) + 127) / 255;
                return 8'(p > 255 ? 0 : 255 - p);
            end
            cbu_pkg::OP_LERP:     return 8'(clip((e * (255 - amt) + c * amt + 127) / 255));
            default:              return 8'd0;
        endcase
    endfunction

    function automatic t_rgba blend_colour(cbu_pkg::t_op m, logic [7:0] amt,
                                           t_rgba e, t_rgba c);
        t_rgba o;
        if (m > cbu_pkg::OP_LERP) return '{8'd0, 8'd0, 8'd0, 8'd255};
        o.r = blend_lane(m, amt, e.r, c.r);
        o.g = blend_lane(m, amt, e.g, c.g);
        o.b = blend_lane(m, amt, e.b, c.b);
        if (m == cbu_pkg::OP_DODGE || m == cbu_pkg::OP_CBURN || m == cbu_pkg::OP_OVERLAY)
            o.a = e.a;
        else o.a = blend_lane(m, amt, e.a, c.a);
        return o;
    endfunction

    task automatic send_request(cbu_pkg::t_op m, logic [7:0] amt, t_rgba e, t_rgba c);
        while (!no_idle && $urandom_range(99) < 18) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= m;
        amount <= amt;
        ex_col <= e;
        cur_col <= c;
        @(posedge clk);
        while (out_stall) @(posedge clk);
        blend_q = {blend_q, blend_colour(m, amt, e, c)};
        n_sent++;
        @(negedge clk);
    endtask

    function automatic t_rgba rand_rgba();
        return t_rgba'($urandom);
    endfunction

    // channel values biased towards the edges where the modes change branch
    function automatic logic [7:0] edge_val();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd127;
            3: return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_directed();
        cbu_pkg::t_op m;
        for (int k = 0; k < 16; k++) begin
            m = cbu_pkg::t_op'(k);
            send_request(m, 8'hff, '{8'h00, 8'hff, 8'h7f, 8'h80},
                         '{8'hff, 8'h00, 8'h80, 8'h7f});
        end
        send_request(cbu_pkg::OP_DODGE, 8'h00, '{8'hff, 8'hfe, 8'h00, 8'h12},
                     '{8'hff, 8'hff, 8'h01, 8'h00});
        send_request(cbu_pkg::OP_CBURN, 8'h00, '{8'h00, 8'h01, 8'hff, 8'h34},
                     '{8'h00, 8'h00, 8'hff, 8'hff});
        send_request(cbu_pkg::OP_OVERLAY, 8'h80, '{8'h00, 8'hff, 8'h80, 8'h56},
                     '{8'h7f, 8'h80, 8'hff, 8'h00});
        send_request(cbu_pkg::OP_ADDALPHA, 8'h00, '{8'hff, 8'h80, 8'h00, 8'h01},
                     '{8'hff, 8'hff, 8'hff, 8'hff});
        send_request(cbu_pkg::OP_ADDALPHA, 8'hff, '{8'hff, 8'h80, 8'h00, 8'h01},
                     '{8'hff, 8'hff, 8'hff, 8'hff});
        send_request(cbu_pkg::OP_LERP, 8'h00, '{8'h00, 8'hff, 8'h55, 8'haa},
                     '{8'hff, 8'h00, 8'haa, 8'h55});
        send_request(cbu_pkg::OP_LERP, 8'hff, '{8'h00, 8'hff, 8'h55, 8'haa},
                     '{8'hff, 8'h00, 8'haa, 8'h55});
        send_request(cbu_pkg::OP_LERP, 8'h80, '{8'h00, 8'hff, 8'h55, 8'haa},
                     '{8'hff, 8'h00, 8'haa, 8'h55});
    endtask

    task automatic test_random(int count);
        t_rgba e, c;
        logic [7:0] amt;
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(1)) begin
                e = rand_rgba();
                c = rand_rgba();
            end else begin
                e = '{edge_val(), edge_val(), edge_val(), edge_val()};
                c = '{edge_val(), edge_val(), edge_val(), edge_val()};
            end
            amt = ($urandom_range(3) == 0) ? edge_val() : 8'($urandom_range(255));
            send_request(cbu_pkg::t_op'($urandom_range(15)), amt, e, c);
        end
    endtask

    task automatic test_back_to_back(int count);
        no_idle = 1'b1;
        test_random(count);
        no_idle = 1'b0;
    endtask

    // receiver side, stalls at random except during the back-to-back stretch
    always @(negedge clk) begin
        if (!rst_n) in_stall <= 1'b0;
        else in_stall <= !no_idle && $urandom_range(99) < 18;
    end

    always @(posedge clk) begin
        t_rgba want;
        if (rst_n && out_valid && !in_stall) begin
            n_recv++;
            if (blend_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $time, res_col);
            end else begin
                want = blend_q.pop_front();
                if (res_col.r !== want.r)
                    $display("%0t: red expected %h actual %h", $time, want.r, res_col.r);
                if (res_col.g !== want.g)
                    $display("%0t: green expected %h actual %h", $time, want.g, res_col.g);
                if (res_col.b !== want.b)
                    $display("%0t: blue expected %h actual %h", $time, want.b, res_col.b);
                if (res_col.a !== want.a)
                    $display("%0t: alpha expected %h actual %h", $time, want.a, res_col.a);
                if (res_col !== want) errors++;
            end
        end
    end

    // watchdog on cycles with no accepted request or result
    always @(posedge clk) begin
        if ((in_valid && !out_stall) || (out_valid && !in_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 2000) begin
            $display("%0t: timeout", $time);
            $display("** color_blend_unit_core: FAILED **");
            $finish;
        end
    end

    initial begin
        errors = 0;
        n_sent = 0;
        n_recv = 0;
        idle_cycles = 0;
        no_idle = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_stall = 1'b0;
        op = cbu_pkg::OP_KEEP;
        amount = '0;
        ex_col = '0;
        cur_col = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random(500);
        test_back_to_back(200);
        test_random(300);
        in_valid <= 1'b0;
        while (blend_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("covered all 16 modes with edge and random channels: %0d requests, %0d results",
                 n_sent, n_recv);
        if (errors == 0) $display("** color_blend_unit_core: PASSED **");
        else $display("** color_blend_unit_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
+incdir+hdl
hdl/cbu_pkg.sv
hdl/cbu_div.sv
hdl/cbu_chan.sv
hdl/color_blend_unit_core.sv
hdl/cbu_checker.sv
test/tb_color_blend_unit_core.sv
